@@ src/pcnms_pkg.sv @@
package pcnms_pkg;

	localparam int MaxBoxes   = 64;
	localparam int MaxClasses = 128;

	localparam logic [15:0] IouThrReset    = 16'd29491;
	localparam logic [7:0]  NumClassReset  = 8'd80;

	localparam logic CfgIdxThr = 1'b0;
	localparam logic CfgIdxNcl = 1'b1;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_FLUSH = 1'b1
	} req_t;

	typedef struct packed {
		logic [15:0] left_x;
		logic [15:0] top_y;
		logic [15:0] right_x;
		logic [15:0] bottom_y;
		logic [6:0]  label;
		logic [15:0] score;
	} box_t;

	// front to back command
	typedef struct packed {
		req_t req;
		box_t box;
	} cmd_t;

	typedef struct packed {
		box_t box;
		logic box_valid;
		logic last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLS,
		ST_SCAN,
		ST_SCAN_RD,
		ST_CHK_RD,
		ST_CHK_A,
		ST_CHK_B,
		ST_CHK_C,
		ST_CHK_D,
		ST_CHK_E,
		ST_EMIT,
		ST_FINAL
	} back_st_t;

endpackage

@@ src/pcnms_if.sv @@
interface pcnms_in_if;
	import pcnms_pkg::*;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] left_x;
	logic [15:0] top_y;
	logic [15:0] right_x;
	logic [15:0] bottom_y;
	logic [6:0]  class_label;
	logic [15:0] score;
	modport source (output valid, req_type, left_x, top_y, right_x, bottom_y, class_label,
		score, input ready);
	modport sink (input valid, req_type, left_x, top_y, right_x, bottom_y, class_label,
		score, output ready);
endinterface

interface pcnms_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_left_x;
	logic [15:0] out_top_y;
	logic [15:0] out_right_x;
	logic [15:0] out_bottom_y;
	logic [6:0]  out_label;
	logic [15:0] out_score;
	logic        box_valid;
	logic        last;
	modport source (output valid, out_left_x, out_top_y, out_right_x, out_bottom_y,
		out_label, out_score, box_valid, last, input ready);
	modport sink (input valid, out_left_x, out_top_y, out_right_x, out_bottom_y,
		out_label, out_score, box_valid, last, output ready);
endinterface

interface pcnms_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/pcnms_front.sv @@
module pcnms_front
	import pcnms_pkg::*;
#(
	parameter int MAX_CLASSES = MaxClasses
) (
	pcnms_in_if.sink    in_ch,
	input  logic [7:0]  num_classes,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	cmd_t c;
	logic keep;

	// labels out of range are dropped here; a flush always goes through
	always_comb begin
		c.req          = req_t'(in_ch.req_type);
		c.box.left_x   = in_ch.left_x;
		c.box.top_y    = in_ch.top_y;
		c.box.right_x  = in_ch.right_x;
		c.box.bottom_y = in_ch.bottom_y;
		c.box.label    = in_ch.class_label;
		c.box.score    = in_ch.score;
		keep = (c.req == REQ_FLUSH) || (({1'b0, in_ch.class_label} < num_classes)
			&& ({1'b0, in_ch.class_label} < 8'(MAX_CLASSES)));
	end

	assign in_ch.ready = cmd_ready;
	assign cmd_valid   = in_ch.valid && keep;
	assign cmd         = c;

endmodule

@@ src/pcnms_fifo.sv @@
module pcnms_fifo
	import pcnms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

endmodule

@@ src/pcnms_back.sv @@
module pcnms_back
	import pcnms_pkg::*;
#(
	parameter int MAX_BOXES   = MaxBoxes,
	parameter int MAX_CLASSES = MaxClasses
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [15:0] iou_threshold,
	pcnms_out_if.source out_ch
);

	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	box_t            mem_q [MAX_BOXES];
	logic [MAX_BOXES-1:0] done_q;   // emitted or suppressed
	logic [MAX_BOXES-1:0] kept_q;
	logic [CW-1:0]   count_q;
	logic [7:0]      cls_q;
	logic [CW-1:0]   i_q, j_q;
	logic [AW-1:0]   best_q;
	logic            found_q;
	logic [15:0]     bscore_q;
	box_t            rd_q, cand_q, other_q;
	back_st_t        st_q, st_d;

	// iou stages
	logic signed [17:0] ox_s1, oy_s1;
	logic signed [33:0] aa_s1, ab_s1;
	logic signed [35:0] inter_s2, uni_s2;
	logic signed [53:0] lhs_s3, rhs_s3;
	logic signed [35:0] uni_s3;

	logic out_full_q;
	res_t res_q;
	// newest kept box waits here so the final beat of a flush can carry last
	box_t pend_q;
	logic pend_v_q;

	logic [AW-1:0] ia, ja;
	assign ia = i_q[AW-1:0];
	assign ja = j_q[AW-1:0];

	function automatic logic signed [17:0] shl(input logic [15:0] amin, amax, bmin, bmax);
		logic signed [17:0] a0, a1, b0, b1, t, m;
		a0 = {2'b0, amin}; a1 = {2'b0, amax}; b0 = {2'b0, bmin}; b1 = {2'b0, bmax};
		if (a0 > b0) begin
			t = a0; a0 = b0; b0 = t;
			t = a1; a1 = b1; b1 = t;
		end
		m = (a1 < b1) ? a1 : b1;
		return (a1 < b0) ? 18'sd0 : m - b0;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && cmd.req == REQ_LOAD && count_q != CW'(MAX_BOXES))
			mem_q[count_q[AW-1:0]] <= cmd.box;
		rd_q <= mem_q[(st_q == ST_SCAN) ? ia : ja];
		ox_s1 <= shl(cand_q.left_x, cand_q.right_x, other_q.left_x, other_q.right_x);
		oy_s1 <= shl(cand_q.top_y, cand_q.bottom_y, other_q.top_y, other_q.bottom_y);
		aa_s1 <= ($signed({2'b0, cand_q.right_x}) - $signed({2'b0, cand_q.left_x}))
			* ($signed({2'b0, cand_q.bottom_y}) - $signed({2'b0, cand_q.top_y}));
		ab_s1 <= ($signed({2'b0, other_q.right_x}) - $signed({2'b0, other_q.left_x}))
			* ($signed({2'b0, other_q.bottom_y}) - $signed({2'b0, other_q.top_y}));
		inter_s2 <= 36'(ox_s1 * oy_s1);
		uni_s2   <= 36'(aa_s1) + 36'(ab_s1) - 36'(ox_s1 * oy_s1);
		lhs_s3   <= {{2{inter_s2[35]}}, inter_s2, 16'b0};
		rhs_s3   <= 54'($signed({1'b0, iou_threshold}) * uni_s2);
		uni_s3   <= uni_s2;
	end

	logic pass;
	assign pass = (uni_s3 == 0) || (uni_s3 > 0 ? lhs_s3 <= rhs_s3 : lhs_s3 >= rhs_s3);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (cmd_valid && cmd_ready && cmd.req == REQ_FLUSH) st_d = ST_CLS;
			ST_CLS: begin
				if (cls_q == 8'(MAX_CLASSES)) st_d = ST_FINAL;
				else st_d = ST_SCAN;
			end
			ST_SCAN: st_d = (i_q == count_q) ? (found_q ? ST_CHK_RD : ST_CLS) : ST_SCAN_RD;
			ST_SCAN_RD: st_d = ST_SCAN;
			ST_CHK_RD: st_d = (j_q == count_q) ? ST_EMIT : ST_CHK_A;
			ST_CHK_A: st_d = (kept_q[ja] && rd_q.label == cls_q[6:0]) ? ST_CHK_B : ST_CHK_RD;
			ST_CHK_B: st_d = ST_CHK_C;
			ST_CHK_C: st_d = ST_CHK_D;
			ST_CHK_D: st_d = ST_CHK_E;
			ST_CHK_E: st_d = pass ? ST_CHK_RD : ST_SCAN;
			ST_EMIT: if (!(pend_v_q && out_full_q)) st_d = ST_SCAN;
			ST_FINAL: if (!out_full_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// back end takes loads only when idle
	assign cmd_ready = st_q == ST_IDLE && !(cmd.req == REQ_FLUSH && out_full_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			done_q <= '0;
			kept_q <= '0;
			out_full_q <= 1'b0;
			cls_q <= '0;
			i_q <= '0;
			j_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			bscore_q <= '0;
			res_q <= '0;
			cand_q <= '0;
			other_q <= '0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_ch.valid && out_ch.ready) out_full_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						if (cmd.req == REQ_LOAD) begin
							if (count_q != CW'(MAX_BOXES)) count_q <= count_q + CW'(1);
						end else begin
							cls_q <= '0;
							done_q <= '0;
							kept_q <= '0;
						end
					end
				end
				ST_CLS: begin
					i_q <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (i_q == count_q) begin
						j_q <= '0;
						cand_q <= mem_q[best_q];
						if (!found_q) cls_q <= cls_q + 8'd1;
					end
				end
				ST_SCAN_RD: begin
					// first strict maximum wins ties: load order
					if (!done_q[ia] && rd_q.label == cls_q[6:0]
						&& (!found_q || rd_q.score > bscore_q)) begin
						found_q <= 1'b1;
						best_q <= ia;
						bscore_q <= rd_q.score;
					end
					i_q <= i_q + CW'(1);
				end
				ST_CHK_RD: ;
				ST_CHK_A: begin
					other_q <= rd_q;
					if (!(kept_q[ja] && rd_q.label == cls_q[6:0])) j_q <= j_q + CW'(1);
				end
				ST_CHK_B: ;
				ST_CHK_C: ;
				ST_CHK_D: ;
				ST_CHK_E: begin
					j_q <= j_q + CW'(1);
					if (!pass) begin
						done_q[best_q] <= 1'b1;
						i_q <= '0;
						found_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (!(pend_v_q && out_full_q)) begin
						done_q[best_q] <= 1'b1;
						kept_q[best_q] <= 1'b1;
						pend_q <= cand_q;
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							out_full_q <= 1'b1;
							res_q <= {pend_q, 1'b1, 1'b0};
						end
						i_q <= '0;
						found_q <= 1'b0;
					end
				end
				ST_FINAL: begin
					if (!out_full_q) begin
						out_full_q <= 1'b1;
						if (pend_v_q) res_q <= {pend_q, 1'b1, 1'b1};
						else res_q <= {box_t'('0), 1'b0, 1'b1};
						pend_v_q <= 1'b0;
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid        = out_full_q;
	assign out_ch.out_left_x   = res_q.box.left_x;
	assign out_ch.out_top_y    = res_q.box.top_y;
	assign out_ch.out_right_x  = res_q.box.right_x;
	assign out_ch.out_bottom_y = res_q.box.bottom_y;
	assign out_ch.out_label    = res_q.box.label;
	assign out_ch.out_score    = res_q.box.score;
	assign out_ch.box_valid    = res_q.box_valid;
	assign out_ch.last         = res_q.last;

endmodule

@@ src/per_class_box_nms_top.sv @@
// channel  dir  beat
// in_ch    in   one box load or one flush request
// cfg_ch   in   register write: 0 iou_threshold, 1 num_classes
// out_ch   out  one kept box (or an empty marker) with last
// Loads pass through a four-beat queue and are taken while the back end is idle.
// A flush scans the N held boxes once per class, and per picked box scans again and
// checks it against every earlier kept box of its class. Each kept box waits in a
// holding slot so the final beat carries last; the walk stalls at an emit when that
// slot and the output reg are both full, and at the end while the output reg is full.
// Input stalls once the queue fills. arst_n clears counts, marks and control registers.
module per_class_box_nms_top
	import pcnms_pkg::*;
#(
	parameter int MAX_BOXES   = MaxBoxes,
	parameter int MAX_CLASSES = MaxClasses
) (
	input  logic       clk,
	input  logic       arst_n,
	pcnms_in_if.sink   in_ch,
	pcnms_cfg_if.sink  cfg_ch,
	pcnms_out_if.source out_ch
);

	logic [15:0] thr_q;
	logic [7:0]  ncl_q;
	logic        fv, fr, bv, br;
	cmd_t        fc, bc;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IouThrReset;
			ncl_q <= NumClassReset;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == CfgIdxThr) thr_q <= cfg_ch.data;
			else if (cfg_ch.index == CfgIdxNcl) ncl_q <= cfg_ch.data[7:0];
		end
	end

	pcnms_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (.in_ch, .num_classes(ncl_q),
		.cmd_valid(fv), .cmd_ready(fr), .cmd(fc));

	pcnms_fifo u_fifo (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fc),
		.rd_valid(bv), .rd_ready(br), .rd_data(bc));

	pcnms_back #(.MAX_BOXES(MAX_BOXES), .MAX_CLASSES(MAX_CLASSES)) u_back (
		.clk, .arst_n, .cmd_valid(bv), .cmd_ready(br), .cmd(bc),
		.iou_threshold(thr_q), .out_ch);

endmodule
